// ----- design/rbff_pkg.sv -----
// shared constants, types and codes of the ring buffer fir filter
// no dependencies; compiled first
package rbff_pkg;

    localparam int RING_DEPTH = 64;
    localparam int MAX_TAPS   = 64;
    localparam int EFF_TAPS   = (MAX_TAPS < RING_DEPTH) ? MAX_TAPS : RING_DEPTH;

    localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int TAP_AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int IDX_W   = (EFF_TAPS > 1) ? $clog2(EFF_TAPS) : 1;

    localparam int REQ_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int TAPIDX_W = 6;
    localparam int TAPCNT_W = 7;
    localparam int OUT_W    = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = PROD_W + IDX_W + 1;

    localparam int FRAC_BITS = 15;
    localparam int RND_BIAS  = 1 << (FRAC_BITS - 1);
    localparam int OUT_MAX   = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN   = -(1 << (OUT_W - 1));
    localparam int TAPCNT_RST = 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH  = 2'd0,
        REQ_TAP   = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    // one multiply-accumulate beat, aligned with the memory read data
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic zero;
        logic smp_vld;
    } t_beat;

    typedef struct packed {
        logic                    done;
        logic signed [OUT_W-1:0] filtered;
        logic                    saturated;
    } t_mac_res;

endpackage

// ----- design/rbff_if.sv -----
// valid/ready channel interfaces of the ring buffer fir filter
// depends on rbff_pkg
interface rbff_in_if;
    import rbff_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [REQ_W-1:0]           req_type;
    logic signed [SAMPLE_W-1:0] sample;
    logic [TAPIDX_W-1:0]        tap_index;
    logic signed [COEF_W-1:0]   tap_value;

    modport source (output valid, req_type, sample, tap_index, tap_value, input ready);
    modport sink   (input valid, req_type, sample, tap_index, tap_value, output ready);
endinterface

interface rbff_out_if;
    import rbff_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] filtered;
    logic                    saturated;

    modport source (output valid, filtered, saturated, input ready);
    modport sink   (input valid, filtered, saturated, output ready);
endinterface

// ----- design/rbff_ram.sv -----
// generic single-write, single-read synchronous ram, read data is registered
// no dependencies
module rbff_ram #(
    parameter int  DEPTH = 64,
    parameter int  WIDTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/rbff_mac.sv -----
// multiply-accumulate datapath with rounding and saturation
// depends on rbff_pkg
module rbff_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rbff_pkg::t_beat                     i_beat,
    input  logic signed [rbff_pkg::SAMPLE_W-1:0] i_smp,
    input  logic signed [rbff_pkg::COEF_W-1:0]   i_coef,
    output rbff_pkg::t_mac_res                  o_res
);
    import rbff_pkg::*;

    logic signed [SAMPLE_W-1:0] smp_op;
    logic signed [COEF_W-1:0]   coef_op;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_p_v;
    logic                       r_p_first;
    logic                       r_p_last;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    n_acc;
    logic                       r_done;
    logic signed [ACC_W:0]      biased;
    logic signed [ACC_W:0]      shifted;

    // unwritten ring entries read as zero, as does the zero-tap beat
    assign smp_op = (i_beat.smp_vld && !i_beat.zero) ? i_smp : '0;
    // the zero-tap beat reads no coefficient, tap 0 may never have been loaded
    assign coef_op = i_beat.zero ? '0 : i_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v     <= 1'b0;
            r_p_first <= 1'b0;
            r_p_last  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_p_v     <= i_beat.vld;
            r_p_first <= i_beat.first;
            r_p_last  <= i_beat.last;
            r_done    <= r_p_v && r_p_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= smp_op * coef_op;
        if (r_p_v) begin
            r_acc <= n_acc;
        end
    end

    assign n_acc = (r_p_first ? ACC_W'(0) : r_acc) + ACC_W'(r_prod);

    // round half up, floor shift, clip to the output range
    assign biased  = (ACC_W + 1)'(r_acc) + (ACC_W + 1)'(RND_BIAS);
    assign shifted = biased >>> FRAC_BITS;

    always_comb begin
        o_res.done = r_done;
        if (shifted > (ACC_W + 1)'(OUT_MAX)) begin
            o_res.filtered  = OUT_W'(OUT_MAX);
            o_res.saturated = 1'b1;
        end else if (shifted < (ACC_W + 1)'(OUT_MIN)) begin
            o_res.filtered  = OUT_W'(OUT_MIN);
            o_res.saturated = 1'b1;
        end else begin
            o_res.filtered  = shifted[OUT_W-1:0];
            o_res.saturated = 1'b0;
        end
    end
endmodule

// ----- design/rbff_ctrl.sv -----
// request decode, ring pointer, tap sequencer and output register
// depends on rbff_pkg and the channel interfaces
module rbff_ctrl (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    rbff_in_if.sink                               i_req,
    rbff_out_if.source                            o_res,
    input  logic                                  i_cfg_we,
    input  logic [rbff_pkg::TAPCNT_W-1:0]         i_cfg_wdata,
    output logic                                  o_ring_we,
    output logic [rbff_pkg::RING_AW-1:0]          o_ring_waddr,
    output logic [rbff_pkg::SAMPLE_W-1:0]         o_ring_wdata,
    output logic                                  o_ring_re,
    output logic [rbff_pkg::RING_AW-1:0]          o_ring_raddr,
    output logic                                  o_tap_we,
    output logic [rbff_pkg::TAP_AW-1:0]           o_tap_waddr,
    output logic [rbff_pkg::COEF_W-1:0]           o_tap_wdata,
    output logic                                  o_tap_re,
    output logic [rbff_pkg::TAP_AW-1:0]           o_tap_raddr,
    output rbff_pkg::t_beat                       o_beat,
    input  rbff_pkg::t_mac_res                    i_mac
);
    import rbff_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_HOLD  = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [RING_AW-1:0]      r_wp;
    logic [RING_AW-1:0]      r_base;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        r_last;
    logic                    r_zero;
    logic [TAPCNT_W-1:0]     r_tap_count;
    logic [RING_DEPTH-1:0]   r_ring_vld;
    t_beat                   r_beat, n_beat;
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_filtered;
    logic                    r_out_sat;

    logic                    accept;
    logic                    push, tapw, clr;
    logic [TAPCNT_W-1:0]     taps_c;
    logic [RING_AW-1:0]      wp_inc;
    logic [RING_AW:0]        diff;
    logic [RING_AW-1:0]      ring_raddr;
    logic                    out_free;
    logic                    load;

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        push = 1'b0;
        tapw = 1'b0;
        clr  = 1'b0;
        if (accept) begin
            unique case (i_req.req_type)
                REQ_PUSH:  push = 1'b1;
                REQ_TAP:   tapw = (int'(i_req.tap_index) < MAX_TAPS);
                REQ_CLEAR: clr  = 1'b1;
                default:   ;
            endcase
        end
    end

    assign taps_c = (int'(r_tap_count) > EFF_TAPS) ? TAPCNT_W'(EFF_TAPS) : r_tap_count;
    assign wp_inc = (int'(r_wp) == RING_DEPTH - 1) ? '0 : r_wp + 1'b1;

    // ring position of the sample r_idx places back from the newest
    assign diff = {1'b0, r_base} - (RING_AW + 1)'(r_idx);
    always_comb begin
        if (r_base >= RING_AW'(r_idx)) begin
            ring_raddr = diff[RING_AW-1:0];
        end else begin
            ring_raddr = RING_AW'(diff + (RING_AW + 1)'(RING_DEPTH));
        end
    end

    assign o_ring_we    = push;
    assign o_ring_waddr = r_wp;
    assign o_ring_wdata = i_req.sample;
    assign o_ring_re    = (r_state == ST_RUN);
    assign o_ring_raddr = ring_raddr;
    assign o_tap_we     = tapw;
    assign o_tap_waddr  = TAP_AW'(i_req.tap_index);
    assign o_tap_wdata  = i_req.tap_value;
    assign o_tap_re     = (r_state == ST_RUN);
    assign o_tap_raddr  = TAP_AW'(r_idx);
    assign o_beat       = r_beat;

    assign out_free = !r_out_valid || o_res.ready;
    assign load     = out_free && ((r_state == ST_DRAIN && i_mac.done) || r_state == ST_HOLD);

    always_comb begin
        n_state = r_state;
        n_beat  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (push) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_beat.vld     = 1'b1;
                n_beat.first   = (r_idx == '0);
                n_beat.last    = (r_idx == r_last);
                n_beat.zero    = r_zero;
                n_beat.smp_vld = r_ring_vld[ring_raddr];
                if (r_idx == r_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_mac.done) begin
                    n_state = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_ring_vld  <= '0;
            r_tap_count <= TAPCNT_W'(TAPCNT_RST);
            r_beat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_beat  <= n_beat;
            if (i_cfg_we) begin
                r_tap_count <= i_cfg_wdata;
            end
            if (clr) begin
                r_wp       <= '0;
                r_ring_vld <= '0;
            end else if (push) begin
                r_wp             <= wp_inc;
                r_ring_vld[r_wp] <= 1'b1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_base <= r_wp;
            r_idx  <= '0;
            r_zero <= (taps_c == '0);
            r_last <= (taps_c == '0) ? '0 : IDX_W'(taps_c - 1'b1);
        end else if (r_state == ST_RUN) begin
            r_idx <= r_idx + 1'b1;
        end
        if (load) begin
            r_out_filtered <= i_mac.filtered;
            r_out_sat      <= i_mac.saturated;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.filtered  = r_out_filtered;
    assign o_res.saturated = r_out_sat;

    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mac.done |-> r_state == ST_DRAIN)
        else $error("accumulator finished outside drain");

    a_last_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_idx == r_last) |=> (r_state == ST_DRAIN && r_beat.last))
        else $error("last tap beat not flagged");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr |=> (r_wp == '0 && r_ring_vld == '0))
        else $error("clear left ring state behind");

    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_ring_vld[r_base] && r_state == ST_RUN && r_idx == '0))
        else $error("push did not mark its ring entry");
endmodule

// ----- design/ring_buffer_fir_filter_unit.sv -----
// Ring buffer FIR filter, top level.
// Depends on rbff_pkg, the channel interfaces, rbff_ram, rbff_mac and rbff_ctrl.
//
// Requests arrive on i_req (valid/ready). A push transaction writes the sample
// into the ring and returns one result on o_res: the sum of tap i times the
// sample i places back, rounded, shifted right by 15 and clipped to 16 bits,
// with a saturation flag. A tap write loads one coefficient; a clear zeroes
// the ring and the write pointer. Neither returns a result. tap_count is set
// through i_cfg_we / i_cfg_wdata; the user must do so only while no request
// is in flight, as the block itself does not enforce it. A push runs one tap
// beat per tap in use (at most 64, one zero beat when tap_count is zero), then
// drains the accumulator into the output register. Taps are processed one per
// cycle through the sample and tap rams; requests are taken only in idle.
// Reset (synchronous, active low) sets tap_count to 1, the write pointer to 0
// and marks every ring entry as zero through per-entry valid bits, so there
// is no clearing pass. Taps must be written before use.
// If o_res is stalled the finished result waits in the output register; new
// requests are taken meanwhile, and a further push finishing before the
// pending one is taken holds in the block until the register frees.
module ring_buffer_fir_filter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rbff_in_if.sink                       i_req,
    rbff_out_if.source                    o_res,
    input  logic                          i_cfg_we,
    input  logic [rbff_pkg::TAPCNT_W-1:0] i_cfg_wdata
);
    import rbff_pkg::*;

    logic                ring_we;
    logic [RING_AW-1:0]  ring_waddr;
    logic [SAMPLE_W-1:0] ring_wdata;
    logic                ring_re;
    logic [RING_AW-1:0]  ring_raddr;
    logic [SAMPLE_W-1:0] ring_rdata;
    logic                tap_we;
    logic [TAP_AW-1:0]   tap_waddr;
    logic [COEF_W-1:0]   tap_wdata;
    logic                tap_re;
    logic [TAP_AW-1:0]   tap_raddr;
    logic [COEF_W-1:0]   tap_rdata;
    t_beat               beat;
    t_mac_res            mac_res;

    rbff_ram #(
        .DEPTH (RING_DEPTH),
        .WIDTH (SAMPLE_W)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_re    (ring_re),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    rbff_ram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (COEF_W)
    ) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (tap_waddr),
        .i_wdata (tap_wdata),
        .i_re    (tap_re),
        .i_raddr (tap_raddr),
        .o_rdata (tap_rdata)
    );

    rbff_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_res        (o_res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_ring_we    (ring_we),
        .o_ring_waddr (ring_waddr),
        .o_ring_wdata (ring_wdata),
        .o_ring_re    (ring_re),
        .o_ring_raddr (ring_raddr),
        .o_tap_we     (tap_we),
        .o_tap_waddr  (tap_waddr),
        .o_tap_wdata  (tap_wdata),
        .o_tap_re     (tap_re),
        .o_tap_raddr  (tap_raddr),
        .o_beat       (beat),
        .i_mac        (mac_res)
    );

    rbff_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (beat),
        .i_smp   (signed'(ring_rdata)),
        .i_coef  (signed'(tap_rdata)),
        .o_res   (mac_res)
    );
endmodule

// ----- tb/ring_buffer_fir_filter_unit_tb.sv -----
// self-checking testbench of ring_buffer_fir_filter_unit: random push, tap write and clear traffic
// checked against an in-bench filter predictor; depends on rbff_pkg, rbff_if and the design files
`timescale 1ns / 1ps

module ring_buffer_fir_filter_unit_tb;
    import rbff_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int CLK_PERIOD     = 10;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 210;
    localparam int NUM_PHASES     = 9;

    typedef struct packed {
        logic [REQ_W-1:0]           req_type;
        logic signed [SAMPLE_W-1:0] sample;
        logic [TAPIDX_W-1:0]        tap_index;
        logic signed [COEF_W-1:0]   tap_value;
    } t_fir_req;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic                    saturated;
    } t_fir_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [TAPCNT_W-1:0] cfg_wdata = '0;

    logic                       drv_valid = 1'b0;
    logic [REQ_W-1:0]           drv_req_type = '0;
    logic signed [SAMPLE_W-1:0] drv_sample = '0;
    logic [TAPIDX_W-1:0]        drv_tap_index = '0;
    logic signed [COEF_W-1:0]   drv_tap_value = '0;
    logic                       rcv_ready = 1'b0;

    rbff_in_if  req_if ();
    rbff_out_if res_if ();

    assign req_if.valid     = drv_valid;
    assign req_if.req_type  = drv_req_type;
    assign req_if.sample    = drv_sample;
    assign req_if.tap_index = drv_tap_index;
    assign req_if.tap_value = drv_tap_value;
    assign res_if.ready     = rcv_ready;

    ring_buffer_fir_filter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_fir_req request_q[$];
    t_fir_out filter_out_q[$];
    bit       tap_loaded[MAX_TAPS];
    bit       idle_en = 1'b1;
    int       req_issue_cnt = 0;
    int       req_accept_cnt = 0;
    int       err_cnt = 0;

    // predictor state
    logic signed [SAMPLE_W-1:0] ring_model[RING_DEPTH];
    logic signed [COEF_W-1:0]   coef_model[MAX_TAPS];
    logic [RING_AW-1:0]         wr_ptr_model;
    logic [TAPCNT_W-1:0]        tap_cnt_model;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 16);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return $urandom_range(0, 1) ? 16'hffff : 16'h0001;
            3, 4: return 16'($urandom_range(0, 2047) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [15:0] smp,
                             input logic [TAPIDX_W-1:0] idx, input logic [15:0] coef);
        t_fir_req rq;
        rq.req_type  = kind;
        rq.sample    = smp;
        rq.tap_index = idx;
        rq.tap_value = coef;
        if (kind == REQ_TAP) tap_loaded[idx] = 1'b1;
        request_q.push_back(rq);
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || drv_valid || filter_out_q.size() != 0)
            @(posedge i_clk);
        // a trailing tap write or clear may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_request(input t_fir_req rq);
        int unsigned        taps;
        logic [RING_AW-1:0] pos;
        longint             acc;
        longint             y;
        t_fir_out           res;
        case (rq.req_type)
            REQ_TAP: coef_model[rq.tap_index] = rq.tap_value;
            REQ_CLEAR: begin
                foreach (ring_model[i]) ring_model[i] = '0;
                wr_ptr_model = '0;
            end
            REQ_PUSH: begin
                ring_model[wr_ptr_model] = rq.sample;
                wr_ptr_model = wr_ptr_model + 1'b1;
                taps = (tap_cnt_model > EFF_TAPS) ? EFF_TAPS : tap_cnt_model;
                acc = 0;
                for (int i = 0; i < taps; i++) begin
                    pos = RING_AW'(int'(wr_ptr_model) - 1 - i);
                    acc += longint'(ring_model[pos]) * longint'(coef_model[i]);
                end
                y = (acc + RND_BIAS) >>> FRAC_BITS;
                res.saturated = 1'b0;
                if (y > OUT_MAX) begin
                    y = OUT_MAX;
                    res.saturated = 1'b1;
                end else if (y < OUT_MIN) begin
                    y = OUT_MIN;
                    res.saturated = 1'b1;
                end
                res.filtered = y[OUT_W-1:0];
                filter_out_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    // request driver
    always @(negedge i_clk) begin : req_driver
        t_fir_req rq;
        int       req_gap;
        if (!i_rst_n || (drv_valid && req_issue_cnt != req_accept_cnt)) begin
            // hold the pending transaction
        end else if (req_gap > 0) begin
            req_gap--;
            drv_valid <= 1'b0;
        end else if (request_q.size() == 0) begin
            drv_valid <= 1'b0;
        end else begin
            rq = request_q.pop_front();
            drv_req_type  <= rq.req_type;
            drv_sample    <= rq.sample;
            drv_tap_index <= rq.tap_index;
            drv_tap_value <= rq.tap_value;
            drv_valid     <= 1'b1;
            req_issue_cnt++;
            req_gap = idle_en ? pick_gap() : 0;
        end
    end

    // result receiver with random backpressure
    always @(negedge i_clk) begin : res_receiver
        int rcv_stall;
        if (rcv_stall > 0) begin
            rcv_stall--;
            rcv_ready <= 1'b0;
        end else begin
            rcv_ready <= 1'b1;
            if (idle_en && $urandom_range(0, 3) == 0) rcv_stall = pick_gap();
        end
    end

    // monitor, predictor update, checker and watchdog
    always @(posedge i_clk) begin : monitor
        t_fir_out exp_out;
        t_fir_req rq;
        bit       progress;
        int       idle_cycles;
        if (!i_rst_n) begin
            foreach (ring_model[i]) ring_model[i] = '0;
            foreach (coef_model[i]) coef_model[i] = '0;
            wr_ptr_model  = '0;
            tap_cnt_model = TAPCNT_W'(TAPCNT_RST);
            idle_cycles   = 0;
        end else begin
            progress = cfg_we;
            if (cfg_we) tap_cnt_model = cfg_wdata;
            if (res_if.valid && res_if.ready) begin
                progress = 1'b1;
                if (filter_out_q.size() == 0) begin
                    $display("%0t: unexpected result, filtered %0d saturated %0b",
                             $time, res_if.filtered, res_if.saturated);
                    err_cnt++;
                end else begin
                    exp_out = filter_out_q.pop_front();
                    if (res_if.filtered !== exp_out.filtered) begin
                        $display("%0t: filtered mismatch, expected %0d, got %0d",
                                 $time, exp_out.filtered, res_if.filtered);
                        err_cnt++;
                    end
                    if (res_if.saturated !== exp_out.saturated) begin
                        $display("%0t: saturated mismatch, expected %0b, got %0b",
                                 $time, exp_out.saturated, res_if.saturated);
                        err_cnt++;
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                progress = 1'b1;
                rq.req_type  = req_if.req_type;
                rq.sample    = req_if.sample;
                rq.tap_index = req_if.tap_index;
                rq.tap_value = req_if.tap_value;
                apply_request(rq);
                req_accept_cnt++;
            end
            if (progress) begin
                idle_cycles = 0;
            end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("ring_buffer_fir_filter_unit test failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned phase_taps[NUM_PHASES];
        int unsigned eff;
        int unsigned r;
        phase_taps = '{0, 64, 127, 1, 65, 2, 33, 0, 0};
        phase_taps[7] = $urandom_range(1, 64);
        phase_taps[8] = $urandom_range(0, 127);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: single tap at full scale, sample extremes, positive saturation
        queue_req(REQ_TAP, 16'h0000, 6'd0, 16'h7fff);
        queue_req(REQ_PUSH, 16'h7fff, 6'd63, 16'hffff);
        queue_req(REQ_PUSH, 16'h8000, 6'd0, 16'h0000);
        queue_req(REQ_PUSH, 16'h0000, 6'd21, 16'h5555);
        queue_req(REQ_PUSH, 16'h0001, 6'd42, 16'haaaa);
        queue_req(REQ_PUSH, 16'hffff, 6'd0, 16'h0000);
        queue_req(REQ_TAP, 16'hffff, 6'd0, 16'h8000);
        queue_req(REQ_PUSH, 16'h8000, 6'd0, 16'h0000);
        queue_req(REQ_PUSH, 16'h7fff, 6'd0, 16'h0000);
        queue_req(REQ_PUSH, 16'h0001, 6'd0, 16'h0000);
        queue_req(REQ_PUSH, 16'hffff, 6'd0, 16'h0000);
        // unused request code does nothing
        queue_req(REQ_UNUSED, 16'h1234, 6'd0, 16'h4321);
        queue_req(REQ_PUSH, 16'h0100, 6'd0, 16'h0000);
        queue_req(REQ_TAP, 16'h0000, 6'd63, 16'h7fff);
        queue_req(REQ_CLEAR, 16'hffff, 6'd63, 16'hffff);
        queue_req(REQ_TAP, 16'h0000, 6'd0, 16'h4000);
        queue_req(REQ_PUSH, 16'h0003, 6'd0, 16'h0000);
        queue_req(REQ_PUSH, 16'hfffd, 6'd0, 16'h0000);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // sender holds off until every result is back
            wait_idle();
            @(negedge i_clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= phase_taps[p][TAPCNT_W-1:0];
            @(negedge i_clk);
            cfg_we    <= 1'b0;
            idle_en = (p % 4) != 1;

            // every tap in use must be loaded before the first push
            eff = (phase_taps[p] > EFF_TAPS) ? EFF_TAPS : phase_taps[p];
            for (int i = 0; i < eff; i++)
                if (!tap_loaded[i]) queue_req(REQ_TAP, pick_word(), i[TAPIDX_W-1:0], pick_word());

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 78)
                    queue_req(REQ_PUSH, pick_word(), TAPIDX_W'($urandom_range(0, 63)),
                              pick_word());
                else if (r < 90)
                    queue_req(REQ_TAP, pick_word(), TAPIDX_W'($urandom_range(0, 63)),
                              pick_word());
                else if (r < 96)
                    queue_req(REQ_CLEAR, pick_word(), TAPIDX_W'($urandom_range(0, 63)),
                              pick_word());
                else
                    queue_req(REQ_UNUSED, pick_word(), TAPIDX_W'($urandom_range(0, 63)),
                              pick_word());
            end
        end

        wait_idle();
        if (err_cnt == 0)
            $display("ring_buffer_fir_filter_unit test passed");
        else
            $display("ring_buffer_fir_filter_unit test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/rbff_pkg.sv
design/rbff_if.sv
design/rbff_ram.sv
design/rbff_mac.sv
design/rbff_ctrl.sv
design/ring_buffer_fir_filter_unit.sv
tb/ring_buffer_fir_filter_unit_tb.sv
